### rtl/core/swas_pkg.sv
package swas_pkg;

   localparam int WINDOW_MAX_DEF = 64;
   localparam int ALPHABET_DEF   = 26;

   localparam int KIND_W   = 2;
   localparam int LETTER_W = 5;
   localparam int INDEX_W  = 16;
   localparam int TEXT_W   = 17;

   localparam logic [TEXT_W-1:0]  TEXT_COUNT_MAX  = {TEXT_W{1'b1}};
   localparam logic [INDEX_W-1:0] START_INDEX_MAX = {INDEX_W{1'b1}};

   localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PATTERN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd2;

   // histogram update for one request
   typedef struct packed {
      logic                valid;
      logic                clear;
      logic                pat_add;
      logic                win_add;
      logic                win_remove;
      logic [LETTER_W-1:0] letter;
      logic [LETTER_W-1:0] gone;
   } hist_cmd_type;

endpackage

### rtl/core/swas_ram.sv
module swas_ram #(
   parameter int DATA_W = 5,
   parameter int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // read-first on a same-address collision
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/swas_hist.sv
module swas_hist #(
   parameter int WINDOW_MAX = swas_pkg::WINDOW_MAX_DEF,
   parameter int ALPHABET   = swas_pkg::ALPHABET_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  swas_pkg::hist_cmd_type cmd,
   output logic                   all_equal
);

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);

   logic [CNT_W-1:0] pat_cnt_ff [ALPHABET];
   logic [CNT_W-1:0] win_cnt_ff [ALPHABET];
   logic [ALPHABET-1:0] eq;

   for (genvar i = 0; i < ALPHABET; i++) begin : g_lane
      logic             hit_add;
      logic             hit_gone;
      logic             pat_inc;
      logic             win_inc;
      logic             win_dec;
      logic [CNT_W-1:0] pat_cnt_in;
      logic [CNT_W-1:0] win_cnt_in;

      assign hit_add  = (int'(cmd.letter) == i);
      assign hit_gone = (int'(cmd.gone) == i);
      assign pat_inc  = cmd.pat_add && hit_add;
      assign win_inc  = cmd.win_add && hit_add;
      assign win_dec  = cmd.win_remove && hit_gone && (win_cnt_ff[i] != '0);

      always_comb begin
         pat_cnt_in = pat_cnt_ff[i] + CNT_W'(pat_inc);
         win_cnt_in = win_cnt_ff[i] + CNT_W'(win_inc) - CNT_W'(win_dec);
         if (cmd.clear) begin
            pat_cnt_in = '0;
            win_cnt_in = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pat_cnt_ff[i] <= '0;
            win_cnt_ff[i] <= '0;
         end else if (enable && cmd.valid) begin
            pat_cnt_ff[i] <= pat_cnt_in;
            win_cnt_ff[i] <= win_cnt_in;
         end
      end

      assign eq[i] = (pat_cnt_ff[i] == win_cnt_ff[i]);
   end

   assign all_equal = &eq;

endmodule

### rtl/core/sliding_window_anagram_search_top.sv
// channel  dir  ports                                  request
// req      in   req_valid req_ready req_kind req_letter   clear / pattern letter / text letter
// rsp      out  rsp_valid rsp_ready rsp_start_index      start of a matching window
//
// One request per cycle while req_ready is high; a result leaves through the pipeline below.
// Pipeline: front state + ring RAM read, histogram lanes, match compare + output reg.
// Synchronous active-high reset clears all counters and histograms; ring contents kept.
// req_ready falls only while a result sits in the output register unaccepted.
module sliding_window_anagram_search_top #(
   parameter int WINDOW_MAX = swas_pkg::WINDOW_MAX_DEF,
   parameter int ALPHABET   = swas_pkg::ALPHABET_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [swas_pkg::KIND_W-1:0]   req_kind,
   input  logic [swas_pkg::LETTER_W-1:0] req_letter,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [swas_pkg::INDEX_W-1:0]  rsp_start_index
);

   localparam int RW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int AW   = RW + 1;
   localparam int PL_W = $clog2(WINDOW_MAX + 1);
   localparam int TW   = swas_pkg::TEXT_W;
   localparam int IW   = swas_pkg::INDEX_W;
   localparam int LW   = swas_pkg::LETTER_W;

   logic advance;
   logic accept;

   // front state
   logic [PL_W-1:0] plen_ff, plen_in;
   logic [TW-1:0]   text_count_ff, text_count_in;
   logic [RW-1:0]   ring_ff, ring_in;

   // stage 1
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_clear_ff, s1_clear_in;
   logic          s1_pat_ff, s1_pat_in;
   logic          s1_add_ff, s1_add_in;
   logic          s1_remove_ff, s1_remove_in;
   logic          s1_cand_ff, s1_cand_in;
   logic [IW-1:0] s1_start_ff, s1_start_in;
   logic [LW-1:0] s1_letter_ff;

   // stage 2
   logic          s2_cand_ff, s2_cand_in;
   logic [IW-1:0] s2_start_ff;

   // output
   logic          rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0] rsp_start_index_ff;

   logic          is_clear, letter_ok, is_pat, is_text, has_pat;
   logic [TW-1:0] tc_next, start_full;
   logic [AW-1:0] old_diff;
   logic [RW-1:0] old_slot;
   logic [LW-1:0] gone;
   logic          all_equal;

   swas_pkg::hist_cmd_type cmd;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   assign is_clear  = (req_kind == swas_pkg::KIND_CLEAR);
   assign letter_ok = (int'(req_letter) < ALPHABET);
   assign is_pat    = (req_kind == swas_pkg::KIND_PATTERN) && letter_ok
                      && (text_count_ff == '0) && (plen_ff < PL_W'(WINDOW_MAX));
   assign is_text   = (req_kind == swas_pkg::KIND_TEXT) && letter_ok;
   assign has_pat   = (plen_ff != '0);

   assign tc_next    = (text_count_ff == swas_pkg::TEXT_COUNT_MAX) ?
                       text_count_ff : text_count_ff + TW'(1);
   assign start_full = tc_next - TW'(plen_ff);

   assign old_diff = AW'(ring_ff) + AW'(WINDOW_MAX) - AW'(plen_ff);
   assign old_slot = (old_diff >= AW'(WINDOW_MAX)) ?
                     RW'(old_diff - AW'(WINDOW_MAX)) : RW'(old_diff);

   always_comb begin
      plen_in       = plen_ff;
      text_count_in = text_count_ff;
      ring_in       = ring_ff;
      if (is_clear) begin
         plen_in       = '0;
         text_count_in = '0;
         ring_in       = '0;
      end else if (is_pat) begin
         plen_in = plen_ff + PL_W'(1);
      end else if (is_text) begin
         text_count_in = tc_next;
         ring_in       = (ring_ff == RW'(WINDOW_MAX - 1)) ? '0 : ring_ff + RW'(1);
      end
   end

   always_comb begin
      s1_valid_in  = accept && (is_clear || is_pat || is_text);
      s1_clear_in  = is_clear;
      s1_pat_in    = is_pat;
      s1_add_in    = is_text && has_pat;
      s1_remove_in = is_text && has_pat && (text_count_ff >= TW'(plen_ff));
      s1_cand_in   = is_text && has_pat && (tc_next >= TW'(plen_ff));
      s1_start_in  = (start_full > TW'(swas_pkg::START_INDEX_MAX)) ?
                     swas_pkg::START_INDEX_MAX : IW'(start_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff       <= '0;
         text_count_ff <= '0;
         ring_ff       <= '0;
      end else if (accept) begin
         plen_ff       <= plen_in;
         text_count_ff <= text_count_in;
         ring_ff       <= ring_in;
      end
   end

   swas_ram #(
      .DATA_W (LW),
      .DEPTH  (WINDOW_MAX)
   ) u_ring (
      .clock (clock),
      .we    (accept && is_text),
      .waddr (ring_ff),
      .wdata (req_letter),
      .re    (advance),
      .raddr (old_slot),
      .rdata (gone)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_clear_ff  <= s1_clear_in;
         s1_pat_ff    <= s1_pat_in;
         s1_add_ff    <= s1_add_in;
         s1_remove_ff <= s1_remove_in;
         s1_cand_ff   <= s1_cand_in;
         s1_start_ff  <= s1_start_in;
         s1_letter_ff <= req_letter;
      end
   end

   always_comb begin
      cmd.valid      = s1_valid_ff;
      cmd.clear      = s1_clear_ff;
      cmd.pat_add    = s1_pat_ff;
      cmd.win_add    = s1_add_ff;
      cmd.win_remove = s1_remove_ff;
      cmd.letter     = s1_letter_ff;
      cmd.gone       = gone;
   end

   swas_hist #(
      .WINDOW_MAX (WINDOW_MAX),
      .ALPHABET   (ALPHABET)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .cmd       (cmd),
      .all_equal (all_equal)
   );

   assign s2_cand_in = s1_valid_ff && s1_cand_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_cand_ff <= 1'b0;
      end else if (advance) begin
         s2_cand_ff <= s2_cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_start_ff <= s1_start_ff;
      end
   end

   // lanes now hold the counts left by the stage-2 request
   assign rsp_valid_in = advance ? (s2_cand_ff && all_equal) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_start_index_ff <= s2_start_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_start_index = rsp_start_index_ff;

   a_plen_bound: assert property (@(posedge clock) disable iff (reset)
      plen_ff <= PL_W'(WINDOW_MAX))
      else $error("pattern length beyond window");

   a_ring_bound: assert property (@(posedge clock) disable iff (reset)
      ring_ff <= RW'(WINDOW_MAX - 1))
      else $error("ring pointer out of range");

   a_clear_front: assert property (@(posedge clock) disable iff (reset)
      accept && is_clear |=> plen_ff == '0 && text_count_ff == '0 && ring_ff == '0)
      else $error("clear did not reset front state");

   a_plen_frozen: assert property (@(posedge clock) disable iff (reset)
      accept && !is_clear && text_count_ff != '0 |=> $stable(plen_ff))
      else $error("pattern grew after text began");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_cand_ff))
      else $error("result without a candidate");

endmodule
